// ===== design/lcwf_pkg.sv =====
// Shared types and constants of the load-cell weigh filter.
package lcwf_pkg;

  localparam logic [2:0] REG_SAMPLE_COUNT     = 3'd0;
  localparam logic [2:0] REG_TARE_OFFSET      = 3'd1;
  localparam logic [2:0] REG_INV_GAIN         = 3'd2;
  localparam logic [2:0] REG_EMA_ALPHA        = 3'd3;
  localparam logic [2:0] REG_STEADY_LIMIT     = 3'd4;
  localparam logic [2:0] REG_STABLE_UPDATES   = 3'd5;
  localparam logic [2:0] REG_OUT_OF_RANGE     = 3'd7;

  localparam int WEIGHT_BITS = 48;
  localparam logic [47:0] W48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] W48_MIN = 48'h8000_0000_0000;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_DPREP  = 14'b00000000000010,
    ST_DIV    = 14'b00000000000100,
    ST_DEND   = 14'b00000000001000,
    ST_DSUB   = 14'b00000000010000,
    ST_MPREP  = 14'b00000000100000,
    ST_MUL1   = 14'b00000001000000,
    ST_ROUND  = 14'b00000010000000,
    ST_SAT    = 14'b00000100000000,
    ST_DIFF   = 14'b00001000000000,
    ST_MPREP2 = 14'b00010000000000,
    ST_MUL2   = 14'b00100000000000,
    ST_STEP   = 14'b01000000000000,
    ST_UPD    = 14'b10000000000000
  } state_t;

endpackage

// ===== design/load_cell_weigh_filter_core.sv =====
// Load-cell weigh filter: group averaging, scaling, smoothing and stability detection.
// An item that does not complete a conversion group is taken and the core stays ready for
// the next one. An item that completes a group passes through the bit-serial divider that
// forms the average of the group sum, SUMW = SAMPLE_BITS + clog2(MAX_GROUP) + 1 bits wide,
// and then the two shift-and-add multipliers for the gain and the smoothing factor; the
// scaled offset is DW bits wide (25 at the default widths). No new item is taken until the
// result has been loaded into the output register, which then waits for the consumer on
// its own.
module load_cell_weigh_filter_core #(
  parameter int MAX_GROUP   = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // raw_sample
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_tdata,
  // no_response
  input  logic                                      s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // filtered_weight, held_weight, average_raw
  output logic [((96 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  // steady
  output logic                                      m_tuser,
  input  logic                                      cfg_wen,
  input  logic [2:0]                                cfg_index,
  input  logic [47:0]                               cfg_wdata
);
  import lcwf_pkg::*;

  localparam int S     = SAMPLE_BITS;
  localparam int OW    = ((96 + SAMPLE_BITS + 7) / 8) * 8;
  localparam int SUMW  = S + $clog2(MAX_GROUP) + 1;
  localparam int FW    = $clog2(MAX_GROUP + 1);
  localparam int DW    = ((S > 24) ? S : 24) + 1;
  localparam int PW    = DW + 48;
  localparam int QW    = PW - 16;
  localparam int LONG0 = (SUMW > DW) ? SUMW : DW;
  localparam int LONG  = (LONG0 > 17) ? LONG0 : 17;
  localparam int CNTW  = $clog2(LONG);

  logic [4:0]         sample_count;
  logic signed [23:0] tare_offset;
  logic signed [47:0] inv_gain;
  logic [16:0]        ema_alpha;
  logic [46:0]        steady_limit;
  logic [15:0]        stable_updates;

  state_t state;
  logic signed [SUMW-1:0] group_sum;
  logic [FW-1:0]          group_fill;
  logic signed [47:0]     ema_weight;
  logic [15:0]            steady_run;
  logic                   steady_flag;
  logic signed [47:0]     latched_weight;

  logic [CNTW-1:0]     cnt;
  logic                sneg;
  logic [SUMW-1:0]     dq;
  logic [FW:0]         rem;
  logic [FW-1:0]       dvs;
  logic signed [S-1:0] avg;
  logic signed [DW-1:0] dval;
  logic [PW-1:0]       prod;
  logic [47:0]         gmag;
  logic                pneg;
  logic [QW-1:0]       qv;
  logic [47:0]         units;
  logic signed [48:0]  diff;
  logic [65:0]         prod2;
  logic [48:0]         dmag;
  logic                eneg;
  logic [49:0]         smag;

  logic [47:0]   out_filt;
  logic [47:0]   out_held;
  logic [S-1:0]  out_avg;
  logic          out_steady;
  logic          out_valid;

  logic signed [S-1:0]    sample;
  logic signed [SUMW-1:0] sum_next;
  logic [FW-1:0]          fill_next;
  logic [FW-1:0]          nlim;
  logic [FW:0]            rshift;
  logic [48:0]            add1;
  logic [49:0]            add2;
  logic [47:0]            ema_next;
  logic [15:0]            run_next;
  logic [16:0]            alpha_sat;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tuser  = out_steady;
  assign m_tdata  = OW'({out_avg, out_held, out_filt});

  always_comb begin
    sample    = s_tuser ? '0 : $signed(s_tdata[S-1:0]);
    sum_next  = group_sum + SUMW'(sample);
    fill_next = group_fill + FW'(1);
    if (sample_count == 5'd0) begin
      nlim = FW'(1);
    end else if (int'(sample_count) > MAX_GROUP) begin
      nlim = FW'(MAX_GROUP);
    end else begin
      nlim = FW'(sample_count);
    end
    rshift    = {rem[FW-1:0], dq[SUMW-1]};
    add1      = {1'b0, prod[PW-1:DW]} + (prod[0] ? {1'b0, gmag} : 49'd0);
    add2      = {1'b0, prod2[65:17]} + (prod2[0] ? {1'b0, dmag} : 50'd0);
    ema_next  = ema_weight + (eneg ? -smag[47:0] : smag[47:0]);
    run_next  = (steady_run == 16'hFFFF) ? steady_run : steady_run + 16'd1;
    alpha_sat = (ema_alpha > ALPHA_ONE) ? ALPHA_ONE : ema_alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count     <= 5'd5;
      tare_offset      <= '0;
      inv_gain         <= 48'sd4294967296;
      ema_alpha        <= 17'd13107;
      steady_limit     <= 47'd6554;
      stable_updates   <= 16'd15;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT:     sample_count     <= cfg_wdata[4:0];
        REG_TARE_OFFSET:      tare_offset      <= cfg_wdata[23:0];
        REG_INV_GAIN:         inv_gain         <= cfg_wdata;
        REG_EMA_ALPHA:        ema_alpha        <= cfg_wdata[16:0];
        REG_STEADY_LIMIT:     steady_limit     <= cfg_wdata[46:0];
        REG_STABLE_UPDATES:   stable_updates   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      group_sum      <= '0;
      group_fill     <= '0;
      ema_weight     <= '0;
      steady_run     <= '0;
      steady_flag    <= 1'b0;
      latched_weight <= '0;
      out_valid      <= 1'b0;
      cnt            <= '0;
    end else begin
      if (out_valid && m_tready && (state != ST_UPD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            group_sum  <= sum_next;
            group_fill <= fill_next;
            if (fill_next >= nlim) begin
              state <= ST_DPREP;
            end
          end
        end
        ST_DPREP: begin
          sneg       <= group_sum[SUMW-1];
          dq         <= group_sum[SUMW-1] ? -group_sum : group_sum;
          rem        <= '0;
          dvs        <= group_fill;
          cnt        <= '0;
          group_sum  <= '0;
          group_fill <= '0;
          state      <= ST_DIV;
        end
        ST_DIV: begin
          if (rshift >= {1'b0, dvs}) begin
            rem <= rshift - {1'b0, dvs};
            dq  <= {dq[SUMW-2:0], 1'b1};
          end else begin
            rem <= rshift;
            dq  <= {dq[SUMW-2:0], 1'b0};
          end
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(SUMW - 1)) begin
            state <= ST_DEND;
          end
        end
        ST_DEND: begin
          avg   <= sneg ? -dq[S-1:0] : dq[S-1:0];
          state <= ST_DSUB;
        end
        ST_DSUB: begin
          dval  <= DW'(avg) - DW'(tare_offset);
          state <= ST_MPREP;
        end
        ST_MPREP: begin
          prod  <= {48'd0, (dval[DW-1] ? -dval : dval)};
          gmag  <= inv_gain[47] ? -inv_gain : inv_gain;
          pneg  <= dval[DW-1] ^ inv_gain[47];
          cnt   <= '0;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          prod <= {add1, prod[DW-1:1]};
          cnt  <= cnt + CNTW'(1);
          if (cnt == CNTW'(DW - 1)) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          qv    <= prod[PW-1:16] + QW'(pneg && (prod[15:0] != 16'd0));
          state <= ST_SAT;
        end
        ST_SAT: begin
          if (!pneg) begin
            units <= (qv > QW'(W48_MAX)) ? W48_MAX : qv[47:0];
          end else begin
            units <= (qv > QW'(W48_MIN)) ? W48_MIN : -qv[47:0];
          end
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          diff  <= 49'($signed(units)) - 49'(ema_weight);
          state <= ST_MPREP2;
        end
        ST_MPREP2: begin
          prod2 <= {49'd0, alpha_sat};
          dmag  <= diff[48] ? -diff : diff;
          eneg  <= diff[48];
          cnt   <= '0;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          prod2 <= {add2, prod2[16:1]};
          cnt   <= cnt + CNTW'(1);
          if (cnt == CNTW'(16)) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          smag  <= prod2[65:16] + 50'(eneg && (prod2[15:0] != 16'd0));
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (!out_valid || m_tready) begin
            ema_weight <= ema_next;
            out_filt   <= ema_next;
            out_avg    <= avg;
            out_valid  <= 1'b1;
            if (smag < {3'd0, steady_limit}) begin
              steady_run <= run_next;
              if (run_next >= stable_updates) begin
                steady_flag    <= 1'b1;
                latched_weight <= ema_next;
                out_steady     <= 1'b1;
                out_held       <= ema_next;
              end else begin
                out_steady <= steady_flag;
                out_held   <= latched_weight;
              end
            end else begin
              steady_run  <= '0;
              steady_flag <= 1'b0;
              out_steady  <= 1'b0;
              out_held    <= latched_weight;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/lcwf_checker.sv =====
// Port checker for the load-cell weigh filter and its bind statement.
module lcwf_port_checker #(
  parameter int OW = 120
) (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [OW-1:0] m_tdata,
  input logic          m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("Result withdrawn before it was taken.");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result shown straight after reset.");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("Result changed while it waited to be taken.");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !(m_tvalid && !$past(m_tvalid) && $past(s_tready)))
    else $error("Result appeared in the cycle after an item was taken.");

endmodule

bind load_cell_weigh_filter_core lcwf_port_checker #(
  .OW(((96 + SAMPLE_BITS + 7) / 8) * 8)
) u_lcwf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
